// ----- design/swmm_pkg.sv -----
// Shared types and constants for the sliding-window min/max block.
package swmm_pkg;

  // Width of the window length register
  localparam int CFG_BITS = 11;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the incoming sample, update running state
    logic rd_tail;   // read queues at the tail pointer (else at the head)
    logic pop_head;  // drop expired entries from the queue heads
    logic pop_tail;  // drop dominated entries from the queue tails
    logic push;      // write the sample at the queue tails
    logic finish;    // hand off the result, restart the stream on last
  } swmm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic head_pop_any;  // some queue dropped its head this cycle
    logic tail_pop_any;  // some queue dropped its tail this cycle
    logic has_result;    // the current sample produces a result
    logic out_busy;      // output register is full and not being taken
  } swmm_status_t;

endpackage

// ----- design/swmm_if.sv -----
// Stream channel interfaces for samples in and min/max results out.
interface swmm_in_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface swmm_out_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] window_min;
  logic signed [SAMPLE_BITS-1:0] window_max;
  logic                          partial;

  modport source (output valid, output window_min, output window_max, output partial,
                  input ready);
  modport sink   (input valid, input window_min, input window_max, input partial,
                  output ready);
endinterface

// ----- design/sliding_window_min_max.sv -----
// Sliding-window min/max over a signed sample stream using two monotonic queues.
// Per sample: accept, drop expired entries at the queue heads (one drop per cycle), then
// dominated entries at the tails, push, read the heads and load the result register; a
// result still waiting in it holds the sequencer. Reset (rst_n, synchronous, active
// low) empties the queues by pointer and sets the window length to 1; no clear pass.
module sliding_window_min_max #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  swmm_in_if.sink                       in_ch,
  swmm_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [swmm_pkg::CFG_BITS-1:0] cfg_wdata
);

  swmm_pkg::swmm_cmd_t    cmd;
  swmm_pkg::swmm_status_t st;

  // Sequencer
  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Queues, running state and result register
  swmm_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_ch.sample),
    .in_last        (in_ch.last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_window_min (out_ch.window_min),
    .out_window_max (out_ch.window_max),
    .out_partial    (out_ch.partial),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

// ----- design/swmm_ctrl.sv -----
// Sequencer for one sample: head drops, tail drops, push, head read, result.
module swmm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  swmm_pkg::swmm_status_t st,
  output swmm_pkg::swmm_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_TAIL   = 3'd2;
  localparam logic [2:0] S_PUSH   = 3'd3;
  localparam logic [2:0] S_READ   = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.pop_head = 1'b1;
        cmd.rd_tail  = !st.head_pop_any;
        if (!st.head_pop_any) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.pop_tail = 1'b1;
        cmd.rd_tail  = 1'b1;
        if (!st.tail_pop_any) state_nxt = S_PUSH;
      end
      S_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        // hold while a result is due and the output register is still occupied
        if (!(st.has_result && st.out_busy)) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/swmm_datapath.sv -----
// Datapath: two monotonic queues in memory, running extremes, output register.
module swmm_datapath #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              in_last,
  input  logic                              cfg_we,
  input  logic [swmm_pkg::CFG_BITS-1:0]     cfg_wdata,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_window_min,
  output logic signed [SAMPLE_BITS-1:0]     out_window_max,
  output logic                              out_partial,
  input  swmm_pkg::swmm_cmd_t               cmd,
  output swmm_pkg::swmm_status_t            st
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int PW = $clog2(2 * WINDOW_MAX);
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int EW = SAMPLE_BITS + PW;
  localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_MAX - 1);
  localparam logic [PW-1:0] POS_LAST = PW'(2 * WINDOW_MAX - 1);
  localparam logic signed [SAMPLE_BITS-1:0] RUN_MIN_INIT = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] RUN_MAX_INIT =
    {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};

  logic [swmm_pkg::CFG_BITS-1:0]  win_size_r;
  logic [31:0]                    len_ext;
  logic [LW-1:0]                  len;
  logic signed [SAMPLE_BITS-1:0]  samp_r;
  logic                           last_r;
  logic [PW-1:0]                  pos_r;
  logic [PW-1:0]                  item_pos_r;
  logic [LW-1:0]                  fill_r, fill_nxt;
  logic signed [SAMPLE_BITS-1:0]  run_min_r, run_max_r;
  logic                           restart;
  logic [1:0]                     hpop_v, tpop_v;
  logic signed [SAMPLE_BITS-1:0]  qval_v [2];
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_min_r, out_max_r;
  logic                           out_partial_r;
  logic                           load_out;

  // Window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= swmm_pkg::CFG_BITS'(1);
    end else if (cfg_we) begin
      win_size_r <= cfg_wdata;
    end
  end

  // Effective window: zero acts as one, clamp to the queue depth
  always_comb begin
    if (win_size_r == '0) begin
      len_ext = 32'd1;
    end else if (32'(win_size_r) > 32'(WINDOW_MAX)) begin
      len_ext = 32'(WINDOW_MAX);
    end else begin
      len_ext = 32'(win_size_r);
    end
    len = len_ext[LW-1:0];
  end

  assign restart = cmd.finish && last_r;

  // Fill count saturates at the window length
  always_comb begin
    logic [31:0] f1;
    f1 = 32'(fill_r) + 32'd1;
    if (f1 > len_ext) begin
      fill_nxt = len;
    end else begin
      fill_nxt = f1[LW-1:0];
    end
  end

  // Item capture, position counter, running extremes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fill_r    <= '0;
      run_min_r <= RUN_MIN_INIT;
      run_max_r <= RUN_MAX_INIT;
      last_r    <= 1'b0;
    end else if (cmd.accept) begin
      last_r    <= in_last;
      pos_r     <= (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
      fill_r    <= fill_nxt;
      if (in_sample < run_min_r) run_min_r <= in_sample;
      if (in_sample > run_max_r) run_max_r <= in_sample;
    end else if (restart) begin
      pos_r     <= '0;
      fill_r    <= '0;
      run_min_r <= RUN_MIN_INIT;
      run_max_r <= RUN_MAX_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      samp_r     <= in_sample;
      item_pos_r <= pos_r;
    end
  end

  // Queue 0 rises head to tail (minimum), queue 1 falls (maximum)
  for (genvar q = 0; q < 2; q++) begin : g_queue
    localparam bit IS_MIN = (q == 0);

    logic [EW-1:0]                 mem [WINDOW_MAX];
    logic [EW-1:0]                 rdata_r;
    logic [AW-1:0]                 head_r, head_nxt, tail_r, tail_nxt, tail_inc;
    logic [LW-1:0]                 cnt_r, cnt_nxt;
    logic [AW-1:0]                 raddr;
    logic signed [SAMPLE_BITS-1:0] q_val;
    logic [PW-1:0]                 q_pos;
    logic [31:0]                   age;
    logic                          hpop, tpop, beaten;

    assign q_val     = rdata_r[EW-1:PW];
    assign q_pos     = rdata_r[PW-1:0];
    assign qval_v[q] = q_val;

    // Age of the entry read, modulo the position range
    always_comb begin
      if (32'(item_pos_r) >= 32'(q_pos)) begin
        age = 32'(item_pos_r) - 32'(q_pos);
      end else begin
        age = 32'(item_pos_r) + 32'(2 * WINDOW_MAX) - 32'(q_pos);
      end
    end

    assign beaten    = IS_MIN ? (q_val > samp_r) : (q_val < samp_r);
    assign hpop      = cmd.pop_head && (cnt_r != '0) && (age >= len_ext);
    assign tpop      = cmd.pop_tail && (cnt_r != '0) && beaten;
    assign hpop_v[q] = hpop;
    assign tpop_v[q] = tpop;
    assign tail_inc  = (tail_r == LAST_IDX) ? '0 : tail_r + AW'(1);

    // Pointer and count update; tail always equals head + count - 1
    always_comb begin
      head_nxt = head_r;
      tail_nxt = tail_r;
      cnt_nxt  = cnt_r;
      if (restart) begin
        head_nxt = '0;
        tail_nxt = LAST_IDX;
        cnt_nxt  = '0;
      end else if (hpop) begin
        head_nxt = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
        cnt_nxt  = cnt_r - LW'(1);
      end else if (tpop) begin
        tail_nxt = (tail_r == '0) ? LAST_IDX : tail_r - AW'(1);
        cnt_nxt  = cnt_r - LW'(1);
      end else if (cmd.push) begin
        tail_nxt = tail_inc;
        cnt_nxt  = cnt_r + LW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        head_r <= '0;
        tail_r <= LAST_IDX;
        cnt_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
    end

    assign raddr = cmd.rd_tail ? tail_nxt : head_nxt;

    // Entry store: one write, one registered read
    always_ff @(posedge clk) begin
      if (cmd.push) begin
        mem[tail_inc] <= {samp_r, item_pos_r};
      end
      rdata_r <= mem[raddr];
    end
  end

  // Output register
  assign load_out = cmd.finish && st.has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (32'(fill_r) >= len_ext) begin
        out_min_r     <= qval_v[0];
        out_max_r     <= qval_v[1];
        out_partial_r <= 1'b0;
      end else begin
        out_min_r     <= run_min_r;
        out_max_r     <= run_max_r;
        out_partial_r <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_min = out_min_r;
  assign out_window_max = out_max_r;
  assign out_partial    = out_partial_r;

  // Status to the controller
  assign st.head_pop_any = |hpop_v;
  assign st.tail_pop_any = |tpop_v;
  assign st.has_result   = (32'(fill_r) >= len_ext) || last_r;
  assign st.out_busy     = out_valid_r && !out_ready;

endmodule

// ----- test/sliding_window_min_max_tb.sv -----
// Self-checking testbench for sliding_window_min_max: random and directed streams, scoreboard.
module sliding_window_min_max_tb;

  localparam int WINDOW_MAX   = 1024;
  localparam int SAMPLE_BITS  = 32;
  localparam int RANDOM_ITEMS = 1450;
  localparam int DRAIN_CYCLES = 2 * WINDOW_MAX + 16;  // idle wait after the last result, before a window write
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int CFG_BITS     = swmm_pkg::CFG_BITS;

  localparam logic [CFG_BITS-1:0] CFG_FULL = WINDOW_MAX[CFG_BITS-1:0];

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;

  typedef enum int {SHAPE_RANDOM, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING, SHAPE_EXTREMES}
    shape_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } sample_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] lo;
    logic signed [SAMPLE_BITS-1:0] hi;
    logic                          part;
  } extremes_t;

  // One deque entry: sample value and its wrapping stream position
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] val;
    logic [10:0]                   pos;
  } slot_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                             in_valid  = 1'b0;
  logic signed [SAMPLE_BITS-1:0]    in_sample = '0;
  logic                             in_last   = 1'b0;
  logic                             out_ready = 1'b0;
  logic                             cfg_we    = 1'b0;
  logic [CFG_BITS-1:0]              cfg_wdata = '0;

  swmm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  swmm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  assign in_ch.valid  = in_valid;
  assign in_ch.sample = in_sample;
  assign in_ch.last   = in_last;
  assign out_ch.ready = out_ready;

  sliding_window_min_max #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Stimulus and scoreboard storage
  sample_item_t pending_samples[$];
  extremes_t    pending_extremes[$];
  int           samples_queued   = 0;
  int           samples_accepted = 0;
  int           results_seen     = 0;
  int           mismatches       = 0;
  int           cycles           = 0;
  int           send_gap         = 0;
  int           rx_stall         = 0;
  int           hold_left        = 0;
  logic         hold_req         = 1'b0;
  logic         hold_done        = 1'b0;

  // Predictor state
  slot_t                         low_slots[$];   // rising deque, minimum at the front
  slot_t                         high_slots[$];  // falling deque, maximum at the front
  logic [CFG_BITS-1:0]           window_reg;
  logic [10:0]                   stream_pos;
  int                            fill_level;
  logic signed [SAMPLE_BITS-1:0] seen_lo;
  logic signed [SAMPLE_BITS-1:0] seen_hi;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Zero acts as one, oversize clamps to the deque depth
  function automatic int eff_window(logic [CFG_BITS-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_MAX) return WINDOW_MAX;
    return int'(w);
  endfunction

  function automatic bit expired(slot_t s, int len);
    logic [10:0] age;
    age = stream_pos - s.pos;
    return age >= len;
  endfunction

  task automatic restart_stream();
    low_slots.delete();
    high_slots.delete();
    stream_pos = '0;
    fill_level = 0;
    seen_hi    = -SAMPLE_MAX;
    seen_lo    = SAMPLE_MAX;
  endtask

  // Update both deques with one sample and queue the min/max it produces, if any
  task automatic compute_window_extremes(logic signed [SAMPLE_BITS-1:0] s, logic lst);
    int        len;
    slot_t     e;
    extremes_t x;
    len = eff_window(window_reg);
    if (s > seen_hi) seen_hi = s;
    if (s < seen_lo) seen_lo = s;
    e.val = s;
    e.pos = stream_pos;

    while (low_slots.size() != 0 && expired(low_slots[0], len)) low_slots.delete(0);
    while (low_slots.size() != 0 && low_slots[$].val > s)
      low_slots.delete(low_slots.size() - 1);
    if (low_slots.size() < WINDOW_MAX) low_slots.insert(low_slots.size(), e);

    while (high_slots.size() != 0 && expired(high_slots[0], len)) high_slots.delete(0);
    while (high_slots.size() != 0 && high_slots[$].val < s)
      high_slots.delete(high_slots.size() - 1);
    if (high_slots.size() < WINDOW_MAX) high_slots.insert(high_slots.size(), e);

    fill_level++;
    if (fill_level > len) fill_level = len;
    stream_pos = stream_pos + 1'b1;

    if (fill_level >= len) begin
      x.lo   = low_slots[0].val;
      x.hi   = high_slots[0].val;
      x.part = 1'b0;
      pending_extremes.insert(pending_extremes.size(), x);
    end else if (lst) begin
      x.lo   = seen_lo;
      x.hi   = seen_hi;
      x.part = 1'b1;
      pending_extremes.insert(pending_extremes.size(), x);
    end
    if (lst) restart_stream();
  endtask

  // Mostly short gaps, a few long ones; every fourth stretch of the cycle count runs flat out
  function automatic int pick_gap();
    int r;
    if ((cycles / 300) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] next_value(
    shape_t shape, logic signed [SAMPLE_BITS-1:0] prev);
    case (shape)
      SHAPE_NARROW: return $signed($urandom_range(0, 6)) - 3;
      SHAPE_RISING: begin
        if ($urandom_range(0, 15) == 0) return prev - $signed($urandom_range(0, 400));
        return prev + $signed($urandom_range(0, 40));
      end
      SHAPE_FALLING: begin
        if ($urandom_range(0, 15) == 0) return prev + $signed($urandom_range(0, 400));
        return prev - $signed($urandom_range(0, 40));
      end
      SHAPE_EXTREMES: begin
        case ($urandom_range(0, 6))
          0:       return SAMPLE_MIN;
          1:       return SAMPLE_MIN + 1;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          5:       return SAMPLE_MAX - 1;
          default: return SAMPLE_MAX;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic int stream_length(int len);
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(1, 4);
    if (r < 6 && len > 1) return $urandom_range(1, (len > 60) ? 60 : len - 1);
    return len + $urandom_range(0, 30);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_window();
    int r;
    int w;
    r = $urandom_range(0, 99);
    if (r < 50) w = $urandom_range(1, 6);
    else if (r < 70) w = $urandom_range(7, 40);
    else if (r < 78) w = $urandom_range(41, 300);
    else if (r < 84) w = 0;
    else if (r < 90) w = $urandom_range(WINDOW_MAX, 2047);
    else w = $urandom_range(2, 3);
    return w[CFG_BITS-1:0];
  endfunction

  task automatic add_sample(logic signed [SAMPLE_BITS-1:0] s, logic lst);
    sample_item_t it;
    it.sample = s;
    it.last   = lst;
    pending_samples.insert(pending_samples.size(), it);
    samples_queued++;
  endtask

  task automatic add_stream(int n, shape_t shape, bit close);
    logic signed [SAMPLE_BITS-1:0] v;
    v = $urandom;
    for (int i = 0; i < n; i++) begin
      v = next_value(shape, v);
      add_sample(v, close && (i == n - 1));
    end
  endtask

  // Let the block drain completely, then write the window length
  task automatic settle_then_write(logic [CFG_BITS-1:0] w);
    while (samples_accepted != samples_queued) @(posedge clk);
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= w;
    window_reg = w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed streams, then random phases with a fresh window length each
  initial begin : stimulus
    int     random_items;
    int     budget;
    int     used;
    int     n;
    int     len;
    int     ph;
    bit     close;
    shape_t shape;

    window_reg = 1;
    restart_stream();
    while (!rst_n) @(posedge clk);

    // Window of one straight out of reset: field extremes
    add_sample(SAMPLE_MIN, 1'b0);
    add_sample(SAMPLE_MAX, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b1);

    // Short streams that end before the window fills, then last on a full window
    settle_then_write(3);
    add_sample(SAMPLE_MIN, 1'b1);  // running max never rises above -(2^31-1)
    add_sample(SAMPLE_MIN, 1'b0);
    add_sample(SAMPLE_MIN, 1'b1);
    add_sample(SAMPLE_MAX, 1'b1);
    add_sample(5, 1'b0);
    add_sample(-3, 1'b0);
    add_sample(7, 1'b0);
    add_sample(2, 1'b1);
    add_sample(10, 1'b0);          // stream left open across the next write
    add_sample(20, 1'b0);

    // Zero length behaves as one, applied mid-stream
    settle_then_write(0);
    add_sample(30, 1'b0);
    add_sample(-40, 1'b1);

    // Oversize length clamps to the deque depth
    settle_then_write(2047);
    add_sample(1, 1'b0);
    add_sample(2, 1'b0);
    add_sample(3, 1'b1);

    settle_then_write(CFG_FULL);
    add_sample(9, 1'b0);
    add_sample(-9, 1'b1);

    random_items = 0;
    ph = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (ph == 0) begin
        // Back-pressure phase: every transfer but the first yields a result while the receiver holds off
        settle_then_write(2);
        add_stream(220, SHAPE_RANDOM, 1'b1);
        hold_req <= 1'b1;
        random_items += 220;
      end else begin
        settle_then_write(pick_window());
        len = eff_window(window_reg);
        if (len > 40 && len < WINDOW_MAX) begin
          // One stream long enough to slide a mid-size window a good way
          budget = len + $urandom_range(20, 60);
          shape  = shape_t'($urandom_range(0, 4));
          add_stream(budget, shape, 1'b1);
        end else begin
          budget = $urandom_range(40, 140);
          used = 0;
          while (used < budget) begin
            n = stream_length(len);
            close = 1'b1;
            if (used + n >= budget) begin
              n = budget - used;
              close = ($urandom_range(0, 3) != 0);  // sometimes carry the stream over
            end
            shape = shape_t'($urandom_range(0, 4));
            add_stream(n, shape, close);
            used += n;
          end
        end
        random_items += budget;
      end
      ph++;
    end

    while (samples_accepted != samples_queued) @(posedge clk);
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_extremes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Sample driver: predicts each transfer, then waits out a random gap
  always @(posedge clk) begin
    sample_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ch.ready) begin
      if (in_valid) begin
        compute_window_extremes(in_sample, in_last);
        samples_accepted <= samples_accepted + 1;
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        it = pending_samples[0];
        pending_samples.delete(0);
        in_sample <= it.sample;
        in_last   <= it.last;
        in_valid  <= 1'b1;
        send_gap  <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor: compare each transfer against the oldest expectation
  always @(posedge clk) begin
    extremes_t want;
    int        g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else begin
      if (out_ch.valid && out_ready) begin
        if (pending_extremes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result %0d: min %0d max %0d partial %0b", results_seen,
                     out_ch.window_min, out_ch.window_max, out_ch.partial);
          mismatches++;
        end else begin
          want = pending_extremes[0];
          pending_extremes.delete(0);
          if (out_ch.window_min !== want.lo || out_ch.window_max !== want.hi ||
              out_ch.partial !== want.part) begin
            if (mismatches < 10)
              $display("result %0d: expected min %0d max %0d partial %0b, got %0d %0d %0b",
                       results_seen, want.lo, want.hi, want.part,
                       out_ch.window_min, out_ch.window_max, out_ch.partial);
            mismatches++;
          end
        end
        results_seen++;
      end

      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall  <= rx_stall - 1;
        out_ready <= 1'b0;
      end else if (out_ch.valid && out_ready) begin
        g = pick_gap();
        out_ready <= (g == 0);
        rx_stall  <= (g == 0) ? 0 : g - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
design/swmm_pkg.sv
design/swmm_if.sv
design/swmm_ctrl.sv
design/swmm_datapath.sv
design/sliding_window_min_max.sv
test/sliding_window_min_max_tb.sv
